// File: rtl/sorted_set_rank_query_core_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the sorted set rank query core
// Shared concurrent assertion forms, clocked and gated by an active-low reset.
// ----------------------------------------------------------------------------
`ifndef SORTED_SET_RANK_QUERY_CORE_MACROS_SVH
`define SORTED_SET_RANK_QUERY_CORE_MACROS_SVH

// Same-cycle implication: when ante holds, cons must hold at that edge.
`define SSET_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication: when ante holds, cons must hold at the following edge.
`define SSET_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/sset_pkg.sv
// ----------------------------------------------------------------------------
// Sorted set package
// Field types, command and status codes, and the cell control bundle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package sset_pkg;

    localparam int KEY_W    = 32;
    localparam int CMD_W    = 2;
    localparam int STATUS_W = 2;
    localparam int RANK_W   = 7;

    typedef logic        [CMD_W-1:0]    t_cmd;
    typedef logic signed [KEY_W-1:0]    t_key;
    typedef logic        [STATUS_W-1:0] t_status;
    typedef logic        [RANK_W-1:0]   t_rank;

    // Command codes
    localparam t_cmd CMD_INSERT = 2'd0;
    localparam t_cmd CMD_REMOVE = 2'd1;
    localparam t_cmd CMD_QUERY  = 2'd2;
    localparam t_cmd CMD_NONE   = 2'd3;

    // Status codes
    localparam t_status ST_DONE   = 2'd0;
    localparam t_status ST_ABSENT = 2'd1;
    localparam t_status ST_DUP    = 2'd2;
    localparam t_status ST_FULL   = 2'd3;

    // Control broadcast to every cell of the chain
    typedef struct packed {
        logic capture;   // latch compare flags against cmp_key
        t_key cmp_key;   // key of the beat being accepted
        logic ins;       // shift up and place new_key
        logic rem;       // shift down over the matching entry
        t_key new_key;   // key of the beat being applied
    } t_cell_ctl;

endpackage

// File: rtl/sset_if.sv
// ----------------------------------------------------------------------------
// Sorted set channel interfaces
// Valid/ready channels for command beats and result beats.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface sset_cmd_if;
    logic           valid;
    logic           ready;
    sset_pkg::t_cmd command;
    sset_pkg::t_key key;

    modport source (output valid, output command, output key, input ready);
    modport sink   (input valid, input command, input key, output ready);
endinterface

interface sset_res_if;
    logic              valid;
    logic              ready;
    sset_pkg::t_status status;
    sset_pkg::t_rank   rank;

    modport source (output valid, output status, output rank, input ready);
    modport sink   (input valid, input status, input rank, output ready);
endinterface

// File: rtl/sset_cell.sv
// ----------------------------------------------------------------------------
// Sorted set cell
// Holds one key of the sorted row, compares it against a broadcast key and
// takes a neighbor's key when the row shifts.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sset_cell #(
    parameter int INDEX = 0,
    parameter int CNT_W = 7
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  sset_pkg::t_cell_ctl i_ctl,
    input  logic [CNT_W-1:0]    i_count,
    input  logic                i_left_lt,
    input  sset_pkg::t_key      i_left_key,
    input  sset_pkg::t_key      i_right_key,
    output sset_pkg::t_key      o_key,
    output logic                o_lt,
    output logic                o_eq
);
    import sset_pkg::*;

    t_key r_key;
    t_key n_key;
    logic r_lt;
    logic r_eq;
    logic w_occupied;

    // An entry below the fill count holds a live key
    assign w_occupied = CNT_W'(INDEX) < i_count;

    // Latch compare flags when a beat is accepted
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lt <= 1'b0;
            r_eq <= 1'b0;
        end else if (i_ctl.capture) begin
            r_lt <= w_occupied && (r_key < i_ctl.cmp_key);
            r_eq <= w_occupied && (r_key == i_ctl.cmp_key);
        end
    end

    // Keep entries below the split point, shift the rest; hold when idle
    always_comb begin
        n_key = r_key;
        if (i_ctl.ins) begin
            if (!r_lt) begin
                n_key = i_left_lt ? i_ctl.new_key : i_left_key;
            end
        end else if (i_ctl.rem) begin
            if (!r_lt) begin
                n_key = i_right_key;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_key <= n_key;
    end

    assign o_key = r_key;
    assign o_lt  = r_lt;
    assign o_eq  = r_eq;

endmodule

// File: rtl/sset_rank.sv
// ----------------------------------------------------------------------------
// Sorted set rank encoder
// Turns the row's less-than thermometer into a position and derives the
// descending rank from the fill count.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sset_rank #(
    parameter int CAPACITY = 64,
    parameter int CNT_W    = 7
) (
    input  logic [CAPACITY-1:0] i_lt,
    input  logic [CNT_W-1:0]    i_count,
    output sset_pkg::t_rank     o_rank
);
    import sset_pkg::*;

    logic [CAPACITY+1:0] w_ext;
    logic [CNT_W-1:0]    w_pos;
    logic [CNT_W-1:0]    w_diff;

    // Pad the thermometer: always set below the row, clear above it
    assign w_ext = {1'b0, i_lt, 1'b1};

    // Encode the single falling edge of the thermometer
    always_comb begin
        w_pos = '0;
        for (int i = 0; i <= CAPACITY; i++) begin
            if (w_ext[i] && !w_ext[i+1]) begin
                w_pos = w_pos | CNT_W'(i);
            end
        end
    end

    // One plus the number of greater keys
    assign w_diff = i_count - w_pos;
    assign o_rank = RANK_W'(w_diff);

endmodule

// File: rtl/sorted_set_rank_query_core.sv
// ----------------------------------------------------------------------------
// Sorted set rank query core
// Set of distinct signed keys kept in ascending order in a chain of cells,
// with insert, remove and descending-rank query.
//
//   channel  | dir | payload          | beat
//   ---------+-----+------------------+------------------------------
//   i_cmd    | in  | command, key     | one operation
//   o_res    | out | status, rank     | one result per operation
//
// An operation runs in two steps: on acceptance every cell compares its key with
// the incoming key; in the apply state the cells shift and the result register
// loads, and a new beat is taken only once the apply state is left.
// Reset clears the fill count; cell contents stay undefined and are never
// read above the count, so no clearing pass runs.
// A result waiting in the output register does not block acceptance; the
// following operation holds in its apply state until that result is taken.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "sorted_set_rank_query_core_macros.svh"

module sorted_set_rank_query_core #(
    parameter int CAPACITY = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    sset_cmd_if.sink    i_cmd,
    sset_res_if.source  o_res
);
    import sset_pkg::*;

    localparam int CNT_W = $clog2(CAPACITY + 1);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_UPD  = 1'b1;

    logic             r_state;
    logic             n_state;
    t_cmd             r_cmd;
    t_key             r_key;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic             r_out_valid;
    t_status          r_out_status;
    t_rank            r_out_rank;

    logic             w_accept;
    logic             w_fire;
    logic             w_hit;
    logic             w_full;
    logic             w_ins_ok;
    logic             w_rem_ok;
    t_status          w_status;
    t_rank            w_rank;
    t_rank            w_enc_rank;
    t_cell_ctl        w_ctl;

    t_key             w_key [CAPACITY];
    logic [CAPACITY-1:0] w_lt;
    logic [CAPACITY-1:0] w_eq;

    // Handshake
    assign i_cmd.ready = (r_state == S_IDLE);
    assign w_accept    = i_cmd.valid && i_cmd.ready;
    assign w_fire      = (r_state == S_UPD) && (!r_out_valid || o_res.ready);

    // Cell control
    assign w_ctl.capture = w_accept;
    assign w_ctl.cmp_key = i_cmd.key;
    assign w_ctl.ins     = w_fire && w_ins_ok;
    assign w_ctl.rem     = w_fire && w_rem_ok;
    assign w_ctl.new_key = r_key;

    // Chain of cells, smallest key at index zero
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic w_left_lt;
        t_key w_left_key;
        t_key w_right_key;

        if (g == 0) begin : g_first
            assign w_left_lt  = 1'b1;
            assign w_left_key = w_key[g];
        end else begin : g_mid
            assign w_left_lt  = w_lt[g-1];
            assign w_left_key = w_key[g-1];
        end

        if (g == CAPACITY - 1) begin : g_last
            assign w_right_key = w_key[g];
        end else begin : g_inner
            assign w_right_key = w_key[g+1];
        end

        sset_cell #(
            .INDEX (g),
            .CNT_W (CNT_W)
        ) u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_ctl       (w_ctl),
            .i_count     (r_count),
            .i_left_lt   (w_left_lt),
            .i_left_key  (w_left_key),
            .i_right_key (w_right_key),
            .o_key       (w_key[g]),
            .o_lt        (w_lt[g]),
            .o_eq        (w_eq[g])
        );
    end

    // Rank from the compare thermometer
    sset_rank #(
        .CAPACITY (CAPACITY),
        .CNT_W    (CNT_W)
    ) u_rank (
        .i_lt    (w_lt),
        .i_count (r_count),
        .o_rank  (w_enc_rank)
    );

    // Decode the operation against the compare flags
    assign w_hit  = |w_eq;
    assign w_full = (r_count == CNT_W'(CAPACITY));

    always_comb begin
        w_ins_ok = 1'b0;
        w_rem_ok = 1'b0;
        w_status = ST_DONE;
        w_rank   = '0;
        n_count  = r_count;
        unique case (r_cmd)
            CMD_INSERT: begin
                priority if (w_hit) begin
                    w_status = ST_DUP;
                end else if (w_full) begin
                    w_status = ST_FULL;
                end else begin
                    w_ins_ok = 1'b1;
                    n_count  = r_count + 1'b1;
                end
            end
            CMD_REMOVE: begin
                if (!w_hit) begin
                    w_status = ST_ABSENT;
                end else begin
                    w_rem_ok = 1'b1;
                    n_count  = r_count - 1'b1;
                end
            end
            CMD_QUERY: begin
                if (!w_hit) begin
                    w_status = ST_ABSENT;
                end else begin
                    w_rank = w_enc_rank;
                end
            end
            CMD_NONE: begin
                w_status = ST_DONE;
            end
        endcase
    end

    // Sequence: accept, then apply
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (w_accept) n_state = S_UPD;
            S_UPD:  if (w_fire)   n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_fire) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Hold the beat being applied and the result beat
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cmd <= i_cmd.command;
            r_key <= i_cmd.key;
        end
        if (w_fire) begin
            r_out_status <= w_status;
            r_out_rank   <= w_rank;
        end
    end

    assign o_res.valid  = r_out_valid;
    assign o_res.status = r_out_status;
    assign o_res.rank   = r_out_rank;

    // Checks
    `SSET_ASSERT_IMP(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= CNT_W'(CAPACITY),
        "fill count above capacity")
    `SSET_ASSERT_NXT(a_accept_busy, i_clk, i_rst_n, w_accept, !i_cmd.ready,
        "accepted beat did not block the next one")
    `SSET_ASSERT_IMP(a_full_status, i_clk, i_rst_n,
        o_res.valid && (o_res.status == ST_FULL), r_count == CNT_W'(CAPACITY),
        "full status reported with room left")
    `SSET_ASSERT_IMP(a_rank_done, i_clk, i_rst_n,
        o_res.valid && (o_res.rank != '0), o_res.status == ST_DONE,
        "nonzero rank on a failed operation")
    `SSET_ASSERT_IMP(a_unique_match, i_clk, i_rst_n, 1'b1, $onehot0(w_eq),
        "key matched more than one entry")

endmodule

// File: verif/tb.sv
// ----------------------------------------------------------------------------
// Sorted set rank query core testbench
// Drives insert, remove and query beats into the core with random gaps and
// output stalls, predicts every answer from an own sorted copy of the set
// and compares each result beat field by field in arrival order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

import sset_pkg::*;

typedef struct packed {
    t_status status;
    t_rank   rank;
} t_answer;

// Track the set contents and the answers still owed by the core
class rank_scoreboard;
    localparam int CAPACITY = 64;

    t_key    stored[CAPACITY];
    int      fill;
    t_answer owed_answers[$];
    int      errors;

    function new();
        fill   = 0;
        errors = 0;
    endfunction

    // Apply one accepted command beat and queue its answer
    function void note_command(t_cmd c, t_key k);
        int      pos;
        bit      hit;
        t_answer a;
        pos = 0;
        while (pos < fill && stored[pos] < k) pos++;
        hit      = (pos < fill) && (stored[pos] == k);
        a.status = ST_DONE;
        a.rank   = '0;
        case (c)
            CMD_INSERT: begin
                if (hit) begin
                    a.status = ST_DUP;
                end else if (fill >= CAPACITY) begin
                    a.status = ST_FULL;
                end else begin
                    for (int i = fill; i > pos; i--) stored[i] = stored[i-1];
                    stored[pos] = k;
                    fill++;
                end
            end
            CMD_REMOVE: begin
                if (!hit) begin
                    a.status = ST_ABSENT;
                end else begin
                    for (int i = pos; i < fill - 1; i++) stored[i] = stored[i+1];
                    fill--;
                end
            end
            CMD_QUERY: begin
                if (!hit) a.status = ST_ABSENT;
                else a.rank = t_rank'(fill - pos);
            end
            default: ;
        endcase
        owed_answers.push_back(a);
    endfunction

    // Compare one result beat against the oldest owed answer
    function void check_answer(t_status s, t_rank r);
        t_answer a;
        if (owed_answers.size() == 0) begin
            $display("%0t: unexpected result beat status %0d rank %0d", $time, s, r);
            errors++;
            return;
        end
        a = owed_answers.pop_front();
        if (s !== a.status) begin
            $display("%0t: status mismatch expected %0d actual %0d", $time, a.status, s);
            errors++;
        end
        if (r !== a.rank) begin
            $display("%0t: rank mismatch expected %0d actual %0d", $time, a.rank, r);
            errors++;
        end
    endfunction

    function int pending();
        return owed_answers.size();
    endfunction
endclass

module tb;

    localparam int RANDOM_ITEMS = 1350;
    localparam int CALM_ITEMS   = 150;
    localparam int POOL_SIZE    = 80;

    typedef enum logic [1:0] {MIX_FILL, MIX_DRAIN, MIX_EVEN} t_mix;

    logic i_clk;
    logic i_rst_n;
    logic calm;

    sset_cmd_if cmd_ch();
    sset_res_if res_ch();

    rank_scoreboard book = new();

    t_key key_pool[POOL_SIZE];

    sorted_set_rank_query_core u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_ch),
        .o_res   (res_ch)
    );

    // Free-running clock
    initial i_clk = 1'b0;
    always #1 i_clk = ~i_clk;

    // Hard limit on the run
    initial begin
        #500_000;
        $display("** sorted_set_rank_query_core: FAILED **");
        $finish;
    end

    // Check every result beat taken by the sink
    always @(posedge i_clk) begin
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            book.check_answer(res_ch.status, res_ch.rank);
        end
    end

    // Stall the result channel in random bursts, steady once calm
    initial begin
        res_ch.ready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (calm) begin
                res_ch.ready <= 1'b1;
                @(posedge i_clk);
            end else if ($urandom_range(0, 3) == 0) begin
                res_ch.ready <= 1'b1;
                repeat ($urandom_range(1, 30)) @(posedge i_clk);
            end else begin
                res_ch.ready <= 1'($urandom_range(0, 1));
                repeat ($urandom_range(1, 8)) @(posedge i_clk);
            end
        end
    end

    // Drive one command beat and hold it until accepted
    task automatic send_command(t_cmd c, t_key k);
        cmd_ch.valid   <= 1'b1;
        cmd_ch.command <= c;
        cmd_ch.key     <= k;
        do @(posedge i_clk); while (!cmd_ch.ready);
        book.note_command(c, k);
    endtask

    // Drop valid for a random burst now and then
    task automatic maybe_gap();
        if (!calm && $urandom_range(0, 3) == 0) begin
            cmd_ch.valid   <= 1'b0;
            cmd_ch.command <= t_cmd'($urandom_range(0, 3));
            cmd_ch.key     <= t_key'($urandom);
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end
    endtask

    function automatic t_key pick_key();
        if ($urandom_range(0, 99) < 85) return key_pool[$urandom_range(0, POOL_SIZE - 1)];
        return t_key'($urandom);
    endfunction

    function automatic t_cmd pick_command(t_mix mix);
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 2) return CMD_NONE;
        case (mix)
            MIX_FILL:  return (roll < 72) ? CMD_INSERT : (roll < 82) ? CMD_REMOVE : CMD_QUERY;
            MIX_DRAIN: return (roll < 12) ? CMD_INSERT : (roll < 72) ? CMD_REMOVE : CMD_QUERY;
            default:   return (roll < 37) ? CMD_INSERT : (roll < 67) ? CMD_REMOVE : CMD_QUERY;
        endcase
    endfunction

    // Main sequence
    initial begin
        t_mix mix;
        t_key k;
        int   waited;
        mix             = MIX_FILL;
        calm            = 1'b0;
        i_rst_n        <= 1'b0;
        cmd_ch.valid   <= 1'b0;
        cmd_ch.command <= CMD_INSERT;
        cmd_ch.key     <= '0;

        // Key pool with the extremes and their neighbors
        key_pool[0] = 32'sh8000_0000;
        key_pool[1] = 32'sh7FFF_FFFF;
        key_pool[2] = '0;
        key_pool[3] = -32'sd1;
        key_pool[4] = 32'sd1;
        key_pool[5] = 32'sh8000_0001;
        key_pool[6] = 32'sh7FFF_FFFE;
        for (int i = 7; i < POOL_SIZE; i++) key_pool[i] = t_key'($urandom);

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: extremes, duplicates, absent keys, unused command
        send_command(CMD_QUERY,  32'sd7);
        send_command(CMD_REMOVE, 32'sd7);
        send_command(CMD_INSERT, '0);
        send_command(CMD_INSERT, 32'sh7FFF_FFFF);
        send_command(CMD_INSERT, 32'sh8000_0000);
        send_command(CMD_INSERT, -32'sd1);
        send_command(CMD_INSERT, 32'sd1);
        send_command(CMD_INSERT, 32'sh7FFF_FFFF);
        send_command(CMD_QUERY,  32'sh8000_0000);
        send_command(CMD_QUERY,  32'sh7FFF_FFFF);
        send_command(CMD_QUERY,  '0);
        send_command(CMD_QUERY,  -32'sd1);
        send_command(CMD_QUERY,  32'sd7);
        send_command(CMD_REMOVE, 32'sd7);
        send_command(CMD_NONE,   32'sh5A5A_A5A5);
        send_command(CMD_REMOVE, 32'sh7FFF_FFFF);
        send_command(CMD_QUERY,  32'sh8000_0000);
        send_command(CMD_REMOVE, 32'sh8000_0000);
        send_command(CMD_QUERY,  32'sd1);
        send_command(CMD_QUERY,  32'sh7FFF_FFFF);

        // Random: alternate fill, drain and balanced stretches
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 60 == 0) mix = t_mix'($urandom_range(0, 2));
            if (n == RANDOM_ITEMS - CALM_ITEMS) calm = 1'b1;
            maybe_gap();
            k = pick_key();
            send_command(pick_command(mix), k);
        end
        cmd_ch.valid <= 1'b0;

        // Drain outstanding answers, then let the core settle
        waited = 0;
        while (book.pending() != 0 && waited < 10_000) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (10) @(posedge i_clk);

        if (book.errors == 0 && book.pending() == 0) begin
            $display("** sorted_set_rank_query_core: PASSED **");
        end else begin
            $display("** sorted_set_rank_query_core: FAILED **");
        end
        $finish;
    end

endmodule
